// ----- design/cau_pkg.sv -----
// shared constants and types for the cubic audio upsampler
`default_nettype none
package cau_pkg;
    localparam int MAX_CHANNELS_DEF    = 4;
    localparam int SAMPLE_WIDTH_DEF    = 16;
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int MAX_RESULTS         = 64;

    localparam logic [0:0] REG_PHASE_STEP    = 1'b0;
    localparam logic [0:0] REG_CHANNEL_COUNT = 1'b1;

    // job kinds passed from the front to the back: pass-through or interval
    typedef enum logic [1:0] {
        K_PASS     = 2'd0,
        K_INTERVAL = 2'd1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_M3    = 3'd1,
        S_M2    = 3'd2,
        S_M1    = 3'd3,
        S_OUT   = 3'd4,
        S_WAIT  = 3'd5
    } t_state;
endpackage
`default_nettype wire

// ----- design/cau_stream_if.sv -----
// valid/ready channel interfaces for frames and results
`default_nettype none
interface cau_in_if #(parameter int NCH = 4, parameter int SW = 16);
    logic valid;
    logic ready;
    logic signed [SW-1:0] sample [NCH];
    logic end_of_stream;
    modport source (output valid, output sample, output end_of_stream, input ready);
    modport sink (input valid, input sample, input end_of_stream, output ready);
endinterface

interface cau_out_if #(parameter int NCH = 4, parameter int SW = 16);
    logic valid;
    logic ready;
    logic signed [SW-1:0] out [NCH];
    logic run_last;
    modport source (output valid, output out, output run_last, input ready);
    modport sink (input valid, input out, input run_last, output ready);
endinterface
`default_nettype wire

// ----- design/cau_front.sv -----
// front end: history, frame classification, pass and interval jobs into a queue
`default_nettype none
module cau_front #(
    parameter int MAX_CHANNELS    = cau_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH    = cau_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_FRAC_BITS = cau_pkg::PHASE_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cau_in_if.sink    s_in,
    input  wire logic [2:0] i_nch,
    input  wire logic i_pass,
    // job queue write side
    output logic o_job_valid,
    input  wire logic i_job_ready,
    output cau_pkg::t_kind o_job_kind,
    output logic o_job_last,
    output logic o_job_reset_phase,
    output logic signed [SAMPLE_WIDTH-1:0] o_job_p [4][MAX_CHANNELS]
);
    import cau_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_h [3][MAX_CHANNELS];
    logic signed [SAMPLE_WIDTH-1:0] r_cur [MAX_CHANNELS];
    logic [1:0] r_seen;
    logic       r_eos;
    // jobs still to issue for the held frame: 0 none, 1 one (the last), 2 both
    logic [1:0] r_todo;
    logic       r_second;
    logic [1:0] n_seen;
    logic signed [SAMPLE_WIDTH-1:0] cur [MAX_CHANNELS];

    assign s_in.ready = (r_todo == 2'd0);

    always_comb begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            cur[c] = (c < int'(i_nch)) ? s_in.sample[c] : '0;
        end
        n_seen = (r_seen < 2'd3) ? r_seen + 2'd1 : 2'd3;
    end

    // capture frame, shift history and count down accepted jobs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= 2'd0;
            r_todo   <= 2'd0;
            r_eos    <= 1'b0;
            r_second <= 1'b0;
        end else if (s_in.valid && s_in.ready) begin
            r_cur <= cur;
            r_h[0] <= r_h[1];
            r_h[1] <= r_h[2];
            r_h[2] <= cur;
            r_eos  <= s_in.end_of_stream;
            r_seen <= s_in.end_of_stream ? 2'd0 : n_seen;
            r_second <= i_pass || (r_seen == 2'd1);
            if (i_pass) begin
                r_todo <= 2'd1;
            end else begin
                case (r_seen)
                    2'd0: r_todo <= 2'd0;
                    2'd1: r_todo <= s_in.end_of_stream ? 2'd1 : 2'd0;
                    default: r_todo <= s_in.end_of_stream ? 2'd2 : 2'd1;
                endcase
            end
        end else if (o_job_valid && i_job_ready) begin
            r_todo   <= r_todo - 2'd1;
            r_second <= 1'b1;
        end
    end

    // previous history snapshot: after shift, r_h[2] is cur, r_h[1] old[2], r_h[0] old[1]
    logic r_pass_job;
    logic r_first_seen3;
    logic r_seen1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_job    <= 1'b0;
            r_first_seen3 <= 1'b0;
            r_seen1       <= 1'b0;
        end else if (s_in.valid && s_in.ready) begin
            r_pass_job    <= i_pass;
            r_first_seen3 <= (r_seen == 2'd3);
            r_seen1       <= (r_seen == 2'd1);
        end
    end
    logic signed [SAMPLE_WIDTH-1:0] r_old0 [MAX_CHANNELS];
    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) r_old0 <= r_h[0];
    end

    always_comb begin
        o_job_valid = (r_todo != 2'd0);
        o_job_kind  = r_pass_job ? K_PASS : K_INTERVAL;
        o_job_last  = (r_todo == 2'd1);
        o_job_reset_phase = (r_todo == 2'd1) && r_eos;
        if (!r_second) begin
            // regular interval old[1..2] with cur
            o_job_p[0] = r_first_seen3 ? r_old0 : r_h[0];
            o_job_p[1] = r_h[0];
            o_job_p[2] = r_h[1];
            o_job_p[3] = r_cur;
        end else begin
            // flush interval with last frame repeated, two-frame stream doubles its first
            o_job_p[0] = r_seen1 ? r_h[1] : r_h[0];
            o_job_p[1] = r_h[1];
            o_job_p[2] = r_cur;
            o_job_p[3] = r_cur;
        end
        if (r_pass_job) begin
            o_job_p[1] = r_cur;
        end
    end
endmodule
`default_nettype wire

// ----- design/cau_queue.sv -----
// two-entry job queue between front and back
`default_nettype none
module cau_queue #(
    parameter int W = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wvalid,
    output logic      o_wready,
    input  wire logic [W-1:0] i_wdata,
    output logic      o_rvalid,
    input  wire logic i_rready,
    output logic [W-1:0] o_rdata
);
    logic [W-1:0] r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_wready = (r_cnt != 2'd2);
    assign o_rvalid = (r_cnt != 2'd0);
    assign o_rdata  = r_mem[r_rp];

    // write storage, pointer and fill bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_wvalid && o_wready) begin
                r_mem[r_wp] <= i_wdata;
                r_wp <= ~r_wp;
            end
            if (o_rvalid && i_rready) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_wvalid && o_wready} - {1'b0, o_rvalid && i_rready};
        end
    end
endmodule
`default_nettype wire

// ----- design/cau_back.sv -----
// back end: phase loop and cubic evaluation with one shared multiplier
`default_nettype none
module cau_back #(
    parameter int MAX_CHANNELS    = cau_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH    = cau_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_FRAC_BITS = cau_pkg::PHASE_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic [PHASE_FRAC_BITS:0] i_step,
    input  wire logic [2:0] i_nch,
    input  wire logic i_job_valid,
    output logic      o_job_ready,
    input  wire cau_pkg::t_kind i_job_kind,
    input  wire logic i_job_last,
    input  wire logic i_job_reset_phase,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_job_p [4][MAX_CHANNELS],
    cau_out_if.source m_out
);
    import cau_pkg::*;

    localparam int PW = PHASE_FRAC_BITS + 1;
    localparam int CW = SAMPLE_WIDTH + 4;
    localparam int MW = CW + PW + 1;
    localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [PW:0] ONE = (PW+1)'(1) << PHASE_FRAC_BITS;
    localparam logic [PW:0] MIN_STEP = (PW+1)'((ONE + 30) / 31);

    t_state r_st, n_st;
    logic [PW:0] r_ph;
    logic [6:0]  r_cnt;
    logic [CHW-1:0] r_ch;
    logic signed [CW-1:0] r_acc;
    logic signed [SAMPLE_WIDTH-1:0] r_res [MAX_CHANNELS];
    logic r_last_job, r_rst_ph, r_pass;
    logic signed [SAMPLE_WIDTH-1:0] r_p [4][MAX_CHANNELS];
    logic r_ovalid, r_olast;
    logic signed [SAMPLE_WIDTH-1:0] r_out [MAX_CHANNELS];

    // coefficient terms of the current channel
    logic signed [CW-1:0] p0, p1, p2, p3, c1, c2, c3, mop;
    logic signed [MW-1:0] prod;
    logic [CW-1:0] rsh;
    logic signed [CW:0] ysum;
    logic signed [SAMPLE_WIDTH-1:0] ysat;
    logic [PW:0] step_eff, n_ph;
    logic more_out, ch_done;

    always_comb begin
        p0 = CW'(r_p[0][r_ch]); p1 = CW'(r_p[1][r_ch]);
        p2 = CW'(r_p[2][r_ch]); p3 = CW'(r_p[3][r_ch]);
        c1 = p2 - p0;
        c2 = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
        c3 = (p1 - p2) + ((p1 - p2) <<< 1) + p3 - p0;
        case (r_st)
            S_M3:    mop = c3;
            S_M2:    mop = c2 + r_acc;
            default: mop = c1 + r_acc;
        endcase
        prod = MW'(mop) * $signed({1'b0, r_ph[PW-1:0]});
        if (r_st == S_M1)
            rsh = CW'((prod + (MW'(1) <<< PHASE_FRAC_BITS)) >>> (PHASE_FRAC_BITS + 1));
        else
            rsh = CW'((prod + (MW'(1) <<< (PHASE_FRAC_BITS - 1))) >>> PHASE_FRAC_BITS);
        ysum = (CW+1)'(p1) + (CW+1)'($signed(rsh));
        if (ysum > (CW+1)'((1 <<< (SAMPLE_WIDTH-1)) - 1))
            ysat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        else if (ysum < -((CW+1)'(1) <<< (SAMPLE_WIDTH-1)))
            ysat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            ysat = SAMPLE_WIDTH'(ysum);
        step_eff = ((PW+1)'(i_step) < MIN_STEP) ? MIN_STEP : (PW+1)'(i_step);
        n_ph = r_ph + step_eff;
        more_out = (n_ph <= ONE) && (r_cnt < 7'(MAX_RESULTS - 1));
        ch_done = (int'(r_ch) >= int'(i_nch) - 1);
    end

    assign o_job_ready = (r_st == S_IDLE);
    assign m_out.valid = r_ovalid;
    assign m_out.out = r_out;
    assign m_out.run_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else r_st <= n_st;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_job_valid) n_st = (i_job_kind == K_PASS) ? S_OUT : S_M3;
            S_M3:   n_st = S_M2;
            S_M2:   n_st = S_M1;
            S_M1:   n_st = ch_done ? S_OUT : S_M3;
            S_OUT:  if (!r_ovalid || m_out.ready) n_st = S_WAIT;
            S_WAIT: n_st = (more_out && !r_pass) ? S_M3 : S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= '0; r_ovalid <= 1'b0; r_cnt <= '0;
        end else begin
            if (r_ovalid && m_out.ready && r_st != S_OUT) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_job_valid) begin
                    r_p <= i_job_p; r_ch <= '0; r_last_job <= i_job_last;
                    r_rst_ph <= i_job_reset_phase;
                    r_pass <= (i_job_kind == K_PASS);
                    for (int c = 0; c < MAX_CHANNELS; c++) r_res[c] <= i_job_p[1][c];
                end
                S_M3: r_acc <= $signed(rsh);
                S_M2: r_acc <= $signed(rsh);
                S_M1: begin
                    r_res[r_ch] <= ysat;
                    r_ch <= r_ch + CHW'(1);
                end
                S_OUT: if (!r_ovalid || m_out.ready) begin
                    r_ovalid <= 1'b1;
                    for (int c = 0; c < MAX_CHANNELS; c++)
                        r_out[c] <= (c < int'(i_nch)) ? r_res[c] : '0;
                    r_olast <= r_pass || (r_last_job && !(more_out));
                    r_cnt <= r_cnt + 7'd1;
                end
                S_WAIT: begin
                    r_ch <= '0;
                    if (!r_pass) begin
                        if (more_out) r_ph <= n_ph;
                        else begin
                            r_ph <= r_rst_ph ? '0 : n_ph - ONE;
                            if (r_last_job) r_cnt <= '0;
                        end
                    end else begin
                        r_cnt <= '0;
                        if (r_rst_ph) r_ph <= '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/cubic_audio_upsampler.sv -----
// Catmull-Rom cubic audio upsampler, top level
// Frames enter on s_in (valid/ready, beat = one frame of up to four
// channels plus end_of_stream); interpolated frames leave on m_out, one beat
// per output frame, run_last set on the last beat caused by an input frame.
// The front end keeps the three-frame history and queues up to two interval
// jobs per frame; the back end walks the phase and evaluates each channel
// with one shared multiplier, in the multiply steps S_M3, S_M2 and S_M1.
// A frame with phase_step of 1.0 or more is passed through as a single
// output frame. The back end takes one job at a time from the queue,
// computes each output frame channel by channel and loads it into the
// output register; a pass-through job goes to that register directly.
// Reset clears the phase, the frame count, the queue and the output
// register; phase_step resets to 1.0 and channel_count to two.
// When the receiver stalls the result stays in the output register and
// the back end waits; the queue then fills and input ready drops.
// Configuration must be written through i_cfg_we/i_cfg_idx/i_cfg_data only
// while idle; the block itself does not enforce this.
`default_nettype none
module cubic_audio_upsampler #(
    parameter int MAX_CHANNELS    = cau_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH    = cau_pkg::SAMPLE_WIDTH_DEF,
    parameter int PHASE_FRAC_BITS = cau_pkg::PHASE_FRAC_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic i_cfg_idx,
    input  wire logic [PHASE_FRAC_BITS:0] i_cfg_data,
    cau_in_if.sink    s_in,
    cau_out_if.source m_out
);
    import cau_pkg::*;

    localparam int PW = PHASE_FRAC_BITS + 1;
    localparam int QW = 2 + 2 + 4 * MAX_CHANNELS * SAMPLE_WIDTH;

    logic [PW-1:0] r_step;
    logic [2:0]    r_nch;
    logic [2:0]    nch;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= PW'(1) << PHASE_FRAC_BITS;
            r_nch  <= 3'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PHASE_STEP:    r_step <= i_cfg_data;
                REG_CHANNEL_COUNT: r_nch  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign nch = (r_nch == 3'd0) ? 3'd1 :
                 (int'(r_nch) > MAX_CHANNELS) ? 3'(MAX_CHANNELS) : r_nch;

    logic f_valid, f_ready, f_last, f_rst;
    t_kind f_kind;
    logic signed [SAMPLE_WIDTH-1:0] f_p [4][MAX_CHANNELS];
    logic q_valid, q_ready, b_last, b_rst;
    t_kind b_kind;
    logic signed [SAMPLE_WIDTH-1:0] b_p [4][MAX_CHANNELS];
    logic [QW-1:0] q_wd, q_rd;

    cau_front #(.MAX_CHANNELS(MAX_CHANNELS), .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_front (
        .i_clk, .i_rst_n, .s_in, .i_nch(nch),
        .i_pass(r_step[PHASE_FRAC_BITS]),
        .o_job_valid(f_valid), .i_job_ready(f_ready), .o_job_kind(f_kind),
        .o_job_last(f_last), .o_job_reset_phase(f_rst), .o_job_p(f_p));

    // pack the job word for the queue
    always_comb begin
        q_wd[QW-1 -: 2] = f_kind;
        q_wd[QW-3]      = f_last;
        q_wd[QW-4]      = f_rst;
        for (int i = 0; i < 4; i++)
            for (int c = 0; c < MAX_CHANNELS; c++)
                q_wd[(i*MAX_CHANNELS + c)*SAMPLE_WIDTH +: SAMPLE_WIDTH] = f_p[i][c];
    end

    // unpack the job word at the queue head
    always_comb begin
        b_kind = t_kind'(q_rd[QW-1 -: 2]);
        b_last = q_rd[QW-3];
        b_rst  = q_rd[QW-4];
        for (int i = 0; i < 4; i++)
            for (int c = 0; c < MAX_CHANNELS; c++)
                b_p[i][c] = q_rd[(i*MAX_CHANNELS + c)*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    end

    cau_queue #(.W(QW)) u_queue (
        .i_clk, .i_rst_n, .i_wvalid(f_valid), .o_wready(f_ready), .i_wdata(q_wd),
        .o_rvalid(q_valid), .i_rready(q_ready), .o_rdata(q_rd));

    cau_back #(.MAX_CHANNELS(MAX_CHANNELS), .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n, .i_step(r_step), .i_nch(nch),
        .i_job_valid(q_valid), .o_job_ready(q_ready), .i_job_kind(b_kind),
        .i_job_last(b_last), .i_job_reset_phase(b_rst), .i_job_p(b_p), .m_out);

    // front holds a job that the full queue has not accepted
    a_q_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_valid && !f_ready) |=> f_valid)
        else $error("job dropped at queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_out.valid && !m_out.ready) |=> m_out.valid)
        else $error("result lost under stall");
    a_pass_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && q_ready && b_kind == K_PASS) |-> b_last)
        else $error("pass job not last");
endmodule
`default_nettype wire

// ----- tb/sv/tb_cubic_audio_upsampler.sv -----
// testbench for the cubic audio upsampler: directed table, random streams, scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb_cubic_audio_upsampler;
    import cau_pkg::*;

    localparam longint ONE_Q16   = 65536;
    localparam longint STEP_FLOOR = (ONE_Q16 + 30) / 31;
    localparam int     STALL_LIMIT = 20000;
    localparam int     SETTLE_CYCLES = 300;

    typedef struct {
        logic signed [15:0] smp [4];
        bit                 last;
    } t_frame;

    typedef struct {
        int unsigned stp;
        int unsigned nch;
        logic [15:0] smp [4];
        bit          eos;
        bit          typed;
        logic [15:0] xo [4];
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = REG_PHASE_STEP;
    logic [16:0] i_cfg_data = '0;

    cau_in_if  #(.NCH(4), .SW(16)) frame_ch ();
    cau_out_if #(.NCH(4), .SW(16)) interp_ch ();

    cubic_audio_upsampler u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (frame_ch.sink),
        .m_out      (interp_ch.source)
    );

    always #5 i_clk = ~i_clk;

    // resampler mirror
    longint      hist [3][4];
    longint      phase_acc;
    int unsigned seen_cnt;
    int unsigned step_reg;
    int unsigned chan_reg;
    t_frame      pending_frames [$];

    int errors;
    int stall_pct;
    int idle_pct;
    int hold_cycles;
    int quiet_cycles;
    int items_sent;

    function automatic logic signed [15:0] catmull(longint x, longint p0, longint p1,
                                                   longint p2, longint p3);
        longint c1, c2, c3, s3, s2, d, y;
        c1 = p2 - p0;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3 = 3 * (p1 - p2) + p3 - p0;
        s3 = (c3 * x + 32768) >>> 16;
        s2 = ((c2 + s3) * x + 32768) >>> 16;
        d  = ((c1 + s2) * x + 65536) >>> 17;
        y  = p1 + d;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        return y[15:0];
    endfunction

    // walk one interval, one output frame per phase point up to 1.0, at most 64 per run
    task automatic walk_interval(input longint a [4], input longint b [4],
                                 input longint c [4], input longint d [4],
                                 input int nch, input longint stp, ref t_frame run [$]);
        t_frame f;
        while (phase_acc <= ONE_Q16 && run.size() < 64) begin
            for (int k = 0; k < 4; k++)
                f.smp[k] = (k < nch) ? catmull(phase_acc, a[k], b[k], c[k], d[k]) : 16'sd0;
            f.last = 1'b0;
            run.push_back(f);
            phase_acc += stp;
        end
        phase_acc -= ONE_Q16;
    endtask

    task automatic predict_frame(input logic [15:0] smp [4], input bit eos,
                                 ref t_frame run [$]);
        longint      cur [4];
        longint      prev [3][4];
        int          nch;
        longint      stp;
        int unsigned seen;
        t_frame      f;
        nch  = (chan_reg == 0) ? 1 : ((chan_reg > 4) ? 4 : chan_reg);
        stp  = step_reg;
        seen = seen_cnt;
        for (int k = 0; k < 4; k++)
            cur[k] = (k < nch) ? longint'($signed(smp[k])) : 0;
        prev = hist;
        hist[0] = hist[1];
        hist[1] = hist[2];
        hist[2] = cur;
        seen_cnt = (seen < 3) ? seen + 1 : 3;
        if (stp >= ONE_Q16) begin
            for (int k = 0; k < 4; k++) f.smp[k] = cur[k][15:0];
            f.last = 1'b1;
            run.push_back(f);
        end else begin
            if (stp < STEP_FLOOR) stp = STEP_FLOOR;
            if (seen == 1) begin
                if (eos) walk_interval(prev[2], prev[2], cur, cur, nch, stp, run);
            end else if (seen == 2) begin
                walk_interval(prev[1], prev[1], prev[2], cur, nch, stp, run);
                if (eos) walk_interval(prev[1], prev[2], cur, cur, nch, stp, run);
            end else if (seen >= 3) begin
                walk_interval(prev[0], prev[1], prev[2], cur, nch, stp, run);
                if (eos) walk_interval(prev[1], prev[2], cur, cur, nch, stp, run);
            end
            if (run.size() > 0) run[run.size() - 1].last = 1'b1;
        end
        if (eos) begin
            seen_cnt  = 0;
            phase_acc = 0;
        end
    endtask

    // drive one frame and wait for its beat
    task automatic send_frame(input logic [15:0] smp [4], input bit eos, input bit typed,
                              input logic [15:0] xo [4]);
        t_frame run [$];
        t_frame f;
        frame_ch.valid <= 1'b1;
        for (int k = 0; k < 4; k++) frame_ch.sample[k] <= smp[k];
        frame_ch.end_of_stream <= eos;
        do @(posedge i_clk); while (!frame_ch.ready);
        predict_frame(smp, eos, run);
        if (typed) begin
            for (int k = 0; k < 4; k++) f.smp[k] = xo[k];
            f.last = 1'b1;
            run = '{f};
        end
        foreach (run[i]) pending_frames.push_back(run[i]);
        items_sent++;
        while ($urandom_range(99) < idle_pct) begin
            frame_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // drain all expected beats, then give the block time to finish silent work
    task automatic wait_idle();
        frame_ch.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input int unsigned data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[16:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_PHASE_STEP) step_reg = data & 32'h1FFFF;
        else chan_reg = data & 32'h7;
        @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && interp_ch.valid && interp_ch.ready) begin
            if (pending_frames.size() == 0) begin
                $error("unexpected output beat");
                errors++;
            end else begin
                t_frame e;
                e = pending_frames.pop_front();
                for (int k = 0; k < 4; k++)
                    if (interp_ch.out[k] !== e.smp[k]) begin
                        $error("out_%0d: expected %0d, got %0d", k, e.smp[k],
                               interp_ch.out[k]);
                        errors++;
                    end
                if (interp_ch.run_last !== e.last) begin
                    $error("run_last: expected %0d, got %0d", e.last, interp_ch.run_last);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure, with an optional long hold
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            interp_ch.ready <= 1'b0;
            hold_cycles--;
        end else begin
            interp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((frame_ch.valid && frame_ch.ready) || (interp_ch.valid && interp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    t_row dir_tab [19] = '{
        '{65536, 2, '{16'h7fff, 16'h8000, 16'h1111, 16'h2222}, 0, 1,
          '{16'h7fff, 16'h8000, 16'h0000, 16'h0000}},
        '{65536, 2, '{16'h8000, 16'h7fff, 16'h3333, 16'h4444}, 1, 1,
          '{16'h8000, 16'h7fff, 16'h0000, 16'h0000}},
        '{131071, 0, '{16'h0001, 16'hffff, 16'h7fff, 16'h8000}, 0, 1,
          '{16'h0001, 16'h0000, 16'h0000, 16'h0000}},
        '{65536, 7, '{16'h7fff, 16'h8000, 16'h0000, 16'hffff}, 1, 1,
          '{16'h7fff, 16'h8000, 16'h0000, 16'hffff}},
        '{32768, 4, '{16'h1234, 16'h8000, 16'h7fff, 16'h0000}, 1, 0, '{0, 0, 0, 0}},
        '{32768, 4, '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 0, 0, '{0, 0, 0, 0}},
        '{32768, 4, '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 0, 0, '{0, 0, 0, 0}},
        '{32768, 4, '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 0, 0, '{0, 0, 0, 0}},
        '{32768, 4, '{16'h8000, 16'h7fff, 16'h0000, 16'hffff}, 0, 0, '{0, 0, 0, 0}},
        '{32768, 4, '{16'h7fff, 16'h8000, 16'h5555, 16'haaaa}, 1, 0, '{0, 0, 0, 0}},
        '{0, 1, '{16'h7fff, 16'h0000, 16'h0000, 16'h0000}, 0, 0, '{0, 0, 0, 0}},
        '{0, 1, '{16'h8000, 16'h0000, 16'h0000, 16'h0000}, 0, 0, '{0, 0, 0, 0}},
        '{0, 1, '{16'h7fff, 16'h0000, 16'h0000, 16'h0000}, 0, 0, '{0, 0, 0, 0}},
        '{0, 1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1, 0, '{0, 0, 0, 0}},
        '{65535, 3, '{16'h4000, 16'hc000, 16'h7fff, 16'h0000}, 0, 0, '{0, 0, 0, 0}},
        '{65535, 3, '{16'hc000, 16'h4000, 16'h8000, 16'h0000}, 0, 0, '{0, 0, 0, 0}},
        '{65535, 3, '{16'h7fff, 16'h8000, 16'h0001, 16'h0000}, 1, 0, '{0, 0, 0, 0}},
        '{2115, 2, '{16'h8000, 16'h7fff, 16'h0000, 16'h0000}, 0, 0, '{0, 0, 0, 0}},
        '{2115, 2, '{16'h7fff, 16'h8000, 16'h0000, 16'h0000}, 1, 0, '{0, 0, 0, 0}}
    };

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            1: return $urandom_range(65535);
            default: return 16'($signed($urandom_range(16000)) - 8000);
        endcase
    endfunction

    function automatic int unsigned rand_step();
        case ($urandom_range(9))
            0: return $urandom_range(131071, 65536);
            1: return $urandom_range(2115);
            2: return 65535;
            default: return $urandom_range(65535, 9000);
        endcase
    endfunction

    // stimulus
    initial begin
        logic [15:0] smp [4];
        logic [15:0] none [4];
        int unsigned last_stp, last_nch;
        int          len;
        int          phase_no;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 4; k++) hist[i][k] = 0;
        phase_acc = 0;
        seen_cnt = 0;
        step_reg = 65536;
        chan_reg = 2;
        errors = 0;
        stall_pct = 0;
        idle_pct = 0;
        hold_cycles = 0;
        quiet_cycles = 0;
        items_sent = 0;
        none = '{0, 0, 0, 0};
        frame_ch.valid = 1'b0;
        frame_ch.end_of_stream = 1'b0;
        for (int k = 0; k < 4; k++) frame_ch.sample[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        last_stp = 32'hffffffff;
        last_nch = 32'hffffffff;
        foreach (dir_tab[r]) begin
            if (dir_tab[r].stp != last_stp || dir_tab[r].nch != last_nch) begin
                wait_idle();
                write_cfg(REG_PHASE_STEP, dir_tab[r].stp);
                write_cfg(REG_CHANNEL_COUNT, dir_tab[r].nch);
                last_stp = dir_tab[r].stp;
                last_nch = dir_tab[r].nch;
            end
            send_frame(dir_tab[r].smp, dir_tab[r].eos, dir_tab[r].typed, dir_tab[r].xo);
        end

        // random streams, phases rotate through the idling modes
        phase_no = 0;
        while (items_sent < 400) begin
            wait_idle();
            write_cfg(REG_PHASE_STEP, rand_step());
            write_cfg(REG_CHANNEL_COUNT, $urandom_range(7));
            case (phase_no % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            // long receiver hold while frames keep coming
            if (phase_no == 2) hold_cycles = 400;
            for (int s = 0; s < 4; s++) begin
                len = $urandom_range(12, 1);
                for (int n = 0; n < len; n++) begin
                    for (int k = 0; k < 4; k++) smp[k] = rand_sample();
                    send_frame(smp, (n == len - 1) && ($urandom_range(9) != 0), 1'b0, none);
                end
                // sender pause until all output has drained
                if (phase_no == 5 && s == 1) begin
                    frame_ch.valid <= 1'b0;
                    while (pending_frames.size() != 0) @(posedge i_clk);
                end
            end
            phase_no++;
        end

        frame_ch.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_frames.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
design/cau_pkg.sv
design/cau_stream_if.sv
design/cau_front.sv
design/cau_queue.sv
design/cau_back.sv
design/cubic_audio_upsampler.sv
tb/sv/tb_cubic_audio_upsampler.sv
